// ===== rtl/nthal_pkg.sv =====
// ----------------------------------------------------------------------------
// nthal_pkg
// Shared types and constants of the node table heap allocator.
// ----------------------------------------------------------------------------
package nthal_pkg;

	localparam int NODE_COUNT    = 128;
	localparam int ADDRESS_WIDTH = 32;
	localparam int IDX_W         = $clog2(NODE_COUNT);
	localparam int CNT_W         = IDX_W + 1;
	localparam int DATA_W        = 32;
	localparam int CFG_IDX_W     = 1;

	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NODE_COUNT);

	// end-of-region addresses wrap at the address width
	localparam logic [DATA_W-1:0] ADDR_MASK = (ADDRESS_WIDTH >= DATA_W) ? {DATA_W{1'b1}} :
		DATA_W'((64'd1 << ADDRESS_WIDTH) - 64'd1);

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_INIT    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FIT   = 2'd1,
		ST_NO_SPARE = 2'd2,
		ST_UNKNOWN  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEAP_BASE = 1'b0,
		CFG_HEAP_SIZE = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [DATA_W-1:0] first_operand;
		logic [DATA_W-1:0] element_size;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] block_address;
	} rsp_t;

	typedef struct packed {
		logic [IDX_W-1:0]  rd_addr;
		logic              st_we;
		logic [IDX_W-1:0]  st_addr;
		logic [DATA_W-1:0] st_data;
		logic              ln_we;
		logic [IDX_W-1:0]  ln_addr;
		logic [DATA_W-1:0] ln_data;
	} mem_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] start;
		logic [DATA_W-1:0] len;
	} mem_rd_t;

endpackage

// ===== rtl/node_table_heap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// node_table_heap_allocator_core
// First-fit allocator over a table of region nodes with free-block coalescing.
//
//   channel   signals                       direction
//   req       req_valid / req_stall / req   in  (operation, operand, size)
//   rsp       rsp_valid / rsp_stall / rsp   out (status, block address)
//   cfg       cfg_we / cfg_index / cfg_data in  (heap base, heap size)
//
// One item at a time; req_stall stays high from accept until the result
// sits in the output register. Allocate does one table scan through the
// node memory read port. Release scans for the node and its free left
// neighbour, then runs coalescing passes, each with one more scan per free node.
// Init and unused codes need no scan. No clearing pass after reset: the
// valid marks are flops. A full output register holds the sequencer.
// ----------------------------------------------------------------------------
module node_table_heap_allocator_core import nthal_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	logic [DATA_W-1:0] heap_base_q, heap_size_q;
	logic              out_valid_q;
	rsp_t              rsp_q;
	logic              idle, res_valid, res_take;
	rsp_t              res;

	assign req_stall = !idle;
	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;
	assign res_take  = res_valid && (!out_valid_q || !rsp_stall);

	nthal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_valid && idle),
		.req       (req),
		.heap_base (heap_base_q),
		.heap_size (heap_size_q),
		.res_take  (res_take),
		.idle      (idle),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0;
			heap_size_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HEAP_BASE: heap_base_q <= cfg_data;
				CFG_HEAP_SIZE: heap_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
			rsp_q       <= res;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/nthal_mem.sv =====
// ----------------------------------------------------------------------------
// nthal_mem
// Node start and length stores, one write port each, shared registered read.
// ----------------------------------------------------------------------------
module nthal_mem import nthal_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output mem_rd_t  rd
);

	logic [DATA_W-1:0] start_mem [NODE_COUNT];
	logic [DATA_W-1:0] len_mem   [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (req.st_we) begin
			start_mem[req.st_addr] <= req.st_data;
		end
		if (req.ln_we) begin
			len_mem[req.ln_addr] <= req.ln_data;
		end
		rd.start <= start_mem[req.rd_addr];
		rd.len   <= len_mem[req.rd_addr];
	end

endmodule

// ===== rtl/nthal_ctrl.sv =====
// ----------------------------------------------------------------------------
// nthal_ctrl
// Sequencer: table scans, carve, release, and repeated coalescing passes.
// Valid and free marks live in flops; start/length live in nthal_mem.
// ----------------------------------------------------------------------------
module nthal_ctrl import nthal_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  req_t              req,
	input  logic [DATA_W-1:0] heap_base,
	input  logic [DATA_W-1:0] heap_size,
	input  logic              res_take,
	output logic              idle,
	output logic              res_valid,
	output rsp_t              res
);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_MUL   = 14'b00000000000010,
		S_ASCAN = 14'b00000000000100,
		S_AWX   = 14'b00000000001000,
		S_AWY   = 14'b00000000010000,
		S_RX    = 14'b00000000100000,
		S_RY    = 14'b00000001000000,
		S_RM    = 14'b00000010000000,
		S_PX    = 14'b00000100000000,
		S_PXRD  = 14'b00001000000000,
		S_PY    = 14'b00010000000000,
		S_PWB   = 14'b00100000000000,
		S_INIT  = 14'b01000000000000,
		S_FIN   = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [DATA_W-1:0] a_q, b_q, need_q;
	logic [DATA_W-1:0] sx_q, lx_q, ly_q, eadr_q;
	logic [IDX_W-1:0]  x_q, y_q;
	logic              xf_q, yf_q, chg_q, mrg_q;
	logic [CNT_W-1:0]  cnt_q, px_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [NODE_COUNT-1:0] valid_q, free_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] addr_q;

	mem_req_t mreq;
	mem_rd_t  mrd;

	logic              scanning, scan_end;
	logic              rx_hit, ry_hit;
	logic [63:0]       prod;
	logic [DATA_W-1:0] rd_end, x_end;
	logic [IDX_W-1:0]  px_idx;

	nthal_mem u_mem (
		.clk (clk),
		.req (mreq),
		.rd  (mrd)
	);

	assign scanning = (state_q == S_ASCAN) || (state_q == S_RX) ||
		(state_q == S_RY) || (state_q == S_PY);
	assign scan_end = (cnt_q == CNT_END) && !pend_s1;
	assign prod     = a_q * b_q;
	assign rd_end   = (mrd.start + mrd.len) & ADDR_MASK;
	assign x_end    = (sx_q + lx_q) & ADDR_MASK;
	assign px_idx   = px_q[IDX_W-1:0];

	// a hit stops the scan; the release-node hit restarts the pointer itself
	assign rx_hit = (state_q == S_RX) && pend_s1 && valid_q[idx_s1] &&
		(mrd.start == a_q);
	assign ry_hit = (state_q == S_RY) && pend_s1 && (idx_s1 != x_q) &&
		valid_q[idx_s1] && free_q[idx_s1] && (rd_end == a_q);

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res.status        = status_q;
	assign res.block_address = addr_q;

	always_comb begin
		mreq = '0;
		mreq.rd_addr = (state_q == S_PX) ? px_idx : cnt_q[IDX_W-1:0];
		unique case (state_q)
			S_AWX: begin
				mreq.ln_we   = 1'b1;
				mreq.ln_addr = x_q;
				mreq.ln_data = lx_q - need_q;
			end
			S_AWY: begin
				mreq.st_we   = 1'b1;
				mreq.st_addr = y_q;
				mreq.st_data = eadr_q;
				mreq.ln_we   = 1'b1;
				mreq.ln_addr = y_q;
				mreq.ln_data = need_q;
			end
			S_RM: begin
				mreq.ln_we   = yf_q;
				mreq.ln_addr = y_q;
				mreq.ln_data = ly_q + lx_q;
			end
			S_PWB: begin
				mreq.ln_we   = mrg_q;
				mreq.ln_addr = px_idx;
				mreq.ln_data = lx_q;
			end
			S_INIT: begin
				mreq.st_we   = 1'b1;
				mreq.st_addr = '0;
				mreq.st_data = heap_base & ADDR_MASK;
				mreq.ln_we   = 1'b1;
				mreq.ln_addr = '0;
				mreq.ln_data = heap_size;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			free_q  <= '0;
			pend_s1 <= 1'b0;
			cnt_q   <= '0;
		end else begin
			// read pipe shared by all table scans
			if (scanning && !rx_hit && !ry_hit) begin
				if (cnt_q != CNT_END) begin
					pend_s1 <= 1'b1;
					idx_s1  <= cnt_q[IDX_W-1:0];
					cnt_q   <= cnt_q + CNT_ONE;
				end else begin
					pend_s1 <= 1'b0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						a_q <= req.first_operand;
						b_q <= req.element_size;
						cnt_q   <= '0;
						pend_s1 <= 1'b0;
						case (req.operation)
							OP_ALLOC:   state_q <= S_MUL;
							OP_RELEASE: state_q <= S_RX;
							OP_INIT:    state_q <= S_INIT;
							default: begin
								status_q <= ST_OK;
								addr_q   <= '0;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_MUL: begin
					need_q  <= prod[DATA_W-1:0];
					xf_q    <= 1'b0;
					yf_q    <= 1'b0;
					state_q <= S_ASCAN;
				end
				S_ASCAN: begin
					if (pend_s1) begin
						if (!xf_q && valid_q[idx_s1] && free_q[idx_s1] &&
							mrd.len >= need_q) begin
							xf_q <= 1'b1;
							x_q  <= idx_s1;
							sx_q <= mrd.start;
							lx_q <= mrd.len;
						end
						if (!yf_q && !valid_q[idx_s1]) begin
							yf_q <= 1'b1;
							y_q  <= idx_s1;
						end
					end
					if (scan_end) begin
						addr_q <= '0;
						if (!xf_q) begin
							status_q <= ST_NO_FIT;
							state_q  <= S_FIN;
						end else if (!yf_q) begin
							status_q <= ST_NO_SPARE;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_AWX;
						end
					end
				end
				S_AWX: begin
					eadr_q  <= (sx_q + (lx_q - need_q)) & ADDR_MASK;
					state_q <= S_AWY;
				end
				S_AWY: begin
					valid_q[y_q] <= 1'b1;
					free_q[y_q]  <= 1'b0;
					status_q     <= ST_OK;
					addr_q       <= eadr_q;
					state_q      <= S_FIN;
				end
				S_RX: begin
					if (rx_hit) begin
						x_q     <= idx_s1;
						lx_q    <= mrd.len;
						yf_q    <= 1'b0;
						pend_s1 <= 1'b0;
						cnt_q   <= '0;
						state_q <= S_RY;
					end else if (scan_end) begin
						status_q <= ST_UNKNOWN;
						addr_q   <= '0;
						state_q  <= S_FIN;
					end
				end
				S_RY: begin
					if (ry_hit) begin
						y_q     <= idx_s1;
						ly_q    <= mrd.len;
						yf_q    <= 1'b1;
						pend_s1 <= 1'b0;
						state_q <= S_RM;
					end else if (scan_end) begin
						state_q <= S_RM;
					end
				end
				S_RM: begin
					if (yf_q) begin
						valid_q[x_q] <= 1'b0;
						free_q[x_q]  <= 1'b0;
					end else begin
						free_q[x_q] <= 1'b1;
					end
					px_q    <= '0;
					chg_q   <= 1'b0;
					state_q <= S_PX;
				end
				S_PX: begin
					if (px_q == CNT_END) begin
						if (chg_q) begin
							px_q  <= '0;
							chg_q <= 1'b0;
						end else begin
							status_q <= ST_OK;
							addr_q   <= '0;
							state_q  <= S_FIN;
						end
					end else if (valid_q[px_idx] && free_q[px_idx]) begin
						state_q <= S_PXRD;
					end else begin
						px_q <= px_q + CNT_ONE;
					end
				end
				S_PXRD: begin
					sx_q    <= mrd.start;
					lx_q    <= mrd.len;
					mrg_q   <= 1'b0;
					cnt_q   <= '0;
					pend_s1 <= 1'b0;
					state_q <= S_PY;
				end
				S_PY: begin
					if (pend_s1 && idx_s1 != px_idx && valid_q[idx_s1] &&
						free_q[idx_s1] && x_end == mrd.start) begin
						lx_q            <= lx_q + mrd.len;
						valid_q[idx_s1] <= 1'b0;
						free_q[idx_s1]  <= 1'b0;
						chg_q           <= 1'b1;
						mrg_q           <= 1'b1;
					end
					if (scan_end) begin
						state_q <= S_PWB;
					end
				end
				S_PWB: begin
					px_q    <= px_q + CNT_ONE;
					state_q <= S_PX;
				end
				S_INIT: begin
					// node 0 holds the whole heap as one free region
					valid_q  <= NODE_COUNT'(1);
					free_q   <= NODE_COUNT'(1);
					status_q <= ST_OK;
					addr_q   <= '0;
					state_q  <= S_FIN;
				end
				S_FIN: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/node_table_heap_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// node_table_heap_allocator_core_tb
// Self-checking bench for the first-fit node table allocator. A scoreboard
// keeps its own copy of the node table, predicts each response from the
// accepted requests, and compares responses in order. The requester works
// in bursts, the response side stalls on its own pattern, and the heap
// registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module node_table_heap_allocator_core_tb;
	import nthal_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	class heap_scoreboard;
		logic [DATA_W-1:0] heap_base, heap_size;
		logic [DATA_W-1:0] n_start[NODE_COUNT];
		logic [DATA_W-1:0] n_len[NODE_COUNT];
		bit                n_free[NODE_COUNT];
		bit                n_valid[NODE_COUNT];
		rsp_t              pending_rsp[$];
		int                errors;

		function new();
			heap_base = '0;
			heap_size = '0;
			errors = 0;
			for (int i = 0; i < NODE_COUNT; i++) drop(i);
		endfunction

		function void drop(int i);
			n_start[i] = '0;
			n_len[i] = '0;
			n_free[i] = 0;
			n_valid[i] = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [DATA_W-1:0] v);
			if (idx == CFG_HEAP_BASE) heap_base = v;
			else heap_size = v;
		endfunction

		function logic [DATA_W-1:0] region_end(int i);
			logic [DATA_W-1:0] e;
			e = n_start[i] + n_len[i];
			return e & ADDR_MASK;
		endfunction

		function rsp_t predict(req_t r);
			rsp_t o;
			logic [DATA_W-1:0] need;
			int x, y;
			bit changed;
			o.status = ST_OK;
			o.block_address = '0;
			case (r.operation)
				OP_ALLOC: begin
					need = r.first_operand * r.element_size;
					for (x = 0; x < NODE_COUNT; x++)
						if (n_valid[x] && n_free[x] && n_len[x] >= need) break;
					if (x == NODE_COUNT) begin
						o.status = ST_NO_FIT;
						return o;
					end
					for (y = 0; y < NODE_COUNT; y++)
						if (y != x && !n_valid[y]) break;
					if (y == NODE_COUNT) begin
						o.status = ST_NO_SPARE;
						return o;
					end
					n_len[x] = n_len[x] - need;
					n_start[y] = region_end(x);
					n_len[y] = need;
					n_free[y] = 0;
					n_valid[y] = 1;
					o.block_address = n_start[y];
				end
				OP_RELEASE: begin
					for (x = 0; x < NODE_COUNT; x++)
						if (n_valid[x] && n_start[x] == r.first_operand) break;
					if (x == NODE_COUNT) begin
						o.status = ST_UNKNOWN;
						return o;
					end
					for (y = 0; y < NODE_COUNT; y++)
						if (y != x && n_valid[y] && n_free[y] && region_end(y) == n_start[x])
							break;
					if (y != NODE_COUNT) begin
						n_len[y] = n_len[y] + n_len[x];
						drop(x);
					end else begin
						n_free[x] = 1;
					end
					// join passes until the table is stable
					do begin
						changed = 0;
						for (int a = 0; a < NODE_COUNT; a++)
							for (int b = 0; b < NODE_COUNT; b++)
								if (a != b && n_valid[a] && n_valid[b] && n_free[a] && n_free[b]
										&& region_end(a) == n_start[b]) begin
									changed = 1;
									n_len[a] = n_len[a] + n_len[b];
									drop(b);
								end
					end while (changed);
				end
				OP_INIT: begin
					for (int i = 0; i < NODE_COUNT; i++) drop(i);
					n_start[0] = heap_base & ADDR_MASK;
					n_len[0] = heap_size;
					n_free[0] = 1;
					n_valid[0] = 1;
				end
				default: ;
			endcase
			return o;
		endfunction

		function void note_request(req_t r);
			pending_rsp.push_back(predict(r));
		endfunction

		function void report_mismatch(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endfunction

		function void check_result(rsp_t got);
			rsp_t exp_rsp;
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("response beat with nothing pending: %h", got));
				return;
			end
			exp_rsp = pending_rsp.pop_front();
			if (got.status !== exp_rsp.status)
				report_mismatch($sformatf("status got %0d want %0d", got.status, exp_rsp.status));
			if (got.block_address !== exp_rsp.block_address)
				report_mismatch($sformatf("block_address got %h want %h",
					got.block_address, exp_rsp.block_address));
		endfunction

		function logic [DATA_W-1:0] live_start();
			logic [DATA_W-1:0] starts[$];
			for (int i = 0; i < NODE_COUNT; i++)
				if (n_valid[i]) starts.push_back(n_start[i]);
			if (starts.size() == 0) return $urandom;
			return starts[$urandom_range(starts.size() - 1)];
		endfunction

		function int pending();
			return pending_rsp.size();
		endfunction
	endclass

	logic                 clk = 0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;

	heap_scoreboard sb = new();
	int             burst_left = 0;
	int             stall_mode = 0;
	int             stall_cnt = 0;

	node_table_heap_allocator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// response side: check accepted beats, stall pattern is re-picked when stall_cnt runs out
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_result(rsp);
		if (stall_cnt == 0) begin
			stall_mode = $urandom_range(3);
			stall_cnt = 256;
		end
		stall_cnt--;
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= $urandom_range(1);
			2: rsp_stall <= ($urandom_range(3) != 0);
			default: rsp_stall <= stall_cnt[5];
		endcase
	end

	task automatic send_beat(input req_t r);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(7) == 0) ? 200 : $urandom_range(1, 20);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(r);
		burst_left--;
	endtask

	task automatic send_op(input logic [1:0] op, input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		req_t r;
		r.operation = op;
		r.first_operand = a;
		r.element_size = b;
		send_beat(r);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_idx_t idx, input logic [DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic random_item(input int alloc_pct);
		int r;
		logic [DATA_W-1:0] a, b;
		r = $urandom_range(99);
		if (r < alloc_pct) begin
			case ($urandom_range(9))
				0: begin a = $urandom; b = $urandom; end
				1: begin a = $urandom_range(1) ? 0 : $urandom; b = $urandom; end
				2: begin a = $urandom_range(1, 3); b = $urandom_range(1, 4096); end
				default: begin a = $urandom_range(0, 4); b = $urandom_range(1, 64); end
			endcase
			send_op(OP_ALLOC, a, b);
		end else if (r < 95) begin
			case ($urandom_range(9))
				0: a = $urandom;
				1, 2: a = sb.live_start() + $urandom_range(1, 8);
				default: a = sb.live_start();
			endcase
			send_op(OP_RELEASE, a, $urandom);
		end else if (r < 97) begin
			send_op(OP_INIT, $urandom, $urandom);
		end else begin
			send_op(OP_UNUSED, $urandom, $urandom);
		end
	endtask

	logic [DATA_W-1:0] phase_base[5] = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_F000, 32'h0};
	logic [DATA_W-1:0] phase_size[5] = '{32'h0, 32'hFFFF_FFFF, 32'h0000_1000, 32'h0000_2000, 32'h0};

	initial begin
		arst_n = 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		rsp_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_HEAP_BASE;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table before any init
		send_op(OP_ALLOC, 32'd1, 32'd1);
		send_op(OP_RELEASE, 32'd0, 32'd0);
		send_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		settle();

		for (int p = 0; p < 5; p++) begin
			if (p == 4) begin
				phase_base[p] = $urandom;
				phase_size[p] = $urandom_range(256, 65536);
			end
			write_cfg(CFG_HEAP_BASE, phase_base[p]);
			write_cfg(CFG_HEAP_SIZE, phase_size[p]);
			send_op(OP_INIT, 32'd0, 32'd0);
			if (p == 0) begin
				send_op(OP_ALLOC, 32'd0, 32'd5);            // zero-sized block
				send_op(OP_ALLOC, 32'h0001_0000, 32'h0001_0000); // product truncates to 0
				send_op(OP_ALLOC, 32'd1, 32'd1);            // nothing fits
				send_op(OP_RELEASE, 32'd0, 32'd0);
				send_op(OP_RELEASE, 32'hDEAD_BEEF, 32'd0);  // unknown address
			end else if (p == 1) begin
				send_op(OP_ALLOC, 32'hFFFF_FFFF, 32'd1);
				send_op(OP_ALLOC, 32'd1, 32'd1);
				send_op(OP_RELEASE, 32'hFFFF_FFFF, 32'd0);  // free node at base
				send_op(OP_RELEASE, 32'hFFFF_FFFF, 32'd0);  // released again
				send_op(OP_RELEASE, 32'h0, 32'd0);
				send_op(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			end else if (p == 3) begin
				// table fills up: lots of tiny blocks in a wrapping heap
				for (int i = 0; i < 10; i++) send_op(OP_ALLOC, 32'd1, 32'd16);
				send_op(OP_UNUSED, 32'd0, 32'd0);
			end
			for (int i = 0; i < 230; i++)
				random_item((p == 3 && i < 130) ? 85 : 55);
			settle();
		end

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#200000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
